// ----- rtl/dnfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dnfr_pkg;

   localparam int DEF_MSG_MAX      = 256;
   localparam int DEF_FRAME_OCTETS = 8;

   // Octets carried in one request, whatever the frame size in use
   localparam int FIELD_OCTETS = 8;
   localparam int OCTET_W      = 8;
   localparam int FRAME_LEN_W  = 4;
   localparam int COUNT_W      = 6;
   localparam int STATUS_W     = 3;
   localparam int MSG_LEN_W    = 9;
   localparam int READ_IDX_W   = 8;

   // Message store is split into byte banks so a whole frame is written at once
   localparam int NUM_BANKS = 8;
   localparam int BANK_W    = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED  = 3'd0,
      ST_STARTED  = 3'd1,
      ST_PROGRESS = 3'd2,
      ST_COMPLETE = 3'd3,
      ST_ERROR    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FT_FIRST  = 2'd0,
      FT_MIDDLE = 2'd1,
      FT_LAST   = 2'd2,
      FT_ACK    = 2'd3
   } frag_kind_type;

   typedef struct packed {
      logic                   func;
      logic [FRAME_LEN_W-1:0] frame_len;
      logic [OCTET_W-1:0]     hdr_octet;
      logic [OCTET_W-1:0]     frag_octet;
      logic [OCTET_W-1:0]     octet_2;
      logic [OCTET_W-1:0]     octet_3;
      logic [OCTET_W-1:0]     octet_4;
      logic [OCTET_W-1:0]     octet_5;
      logic [OCTET_W-1:0]     octet_6;
      logic [OCTET_W-1:0]     octet_7;
      logic [READ_IDX_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [MSG_LEN_W-1:0] msg_len;
      logic                 in_progress;
      logic [OCTET_W-1:0]   read_byte;
   } rsp_type;

   // Write found by one lane: target bank, whether it spills into the next row
   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
      logic              wrap;
      logic [OCTET_W-1:0] data;
   } lane_wr_type;

endpackage

`default_nettype wire

// ----- rtl/dnfr_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dnfr_chan_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/dnfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/dnfr_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnfr_lane
   import dnfr_pkg::*;
#(
   parameter int POS = 1
) (
   input  wire logic                   en,
   input  wire logic [FRAME_LEN_W-1:0] cnt,
   input  wire logic [1:0]             from,
   input  wire logic [BANK_W-1:0]      base_lo,
   input  wire logic [OCTET_W-1:0]     octet,
   output      lane_wr_type            wr
);

   logic [FRAME_LEN_W-1:0] pos_w;
   logic [FRAME_LEN_W-1:0] from_w;
   logic [FRAME_LEN_W-1:0] offset;
   logic [FRAME_LEN_W-1:0] slot;

   // Offset of this octet inside the appended run, then its bank slot
   always_comb begin
      pos_w   = FRAME_LEN_W'(POS);
      from_w  = {2'b00, from};
      offset  = pos_w - from_w;
      slot    = {1'b0, base_lo} + offset;
      wr.valid = en && (pos_w >= from_w) && (pos_w < cnt);
      wr.bank  = slot[BANK_W-1:0];
      wr.wrap  = slot[BANK_W];
      wr.data  = octet;
   end

endmodule

`default_nettype wire

// ----- rtl/dnfr_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dnfr_merge
   import dnfr_pkg::*;
#(
   parameter int LANES = 7,
   parameter int ROW_W = 5
) (
   input  wire lane_wr_type        lane_wr   [LANES],
   input  wire logic [ROW_W-1:0]   base_row,
   output      logic               bank_we   [NUM_BANKS],
   output      logic [ROW_W-1:0]   bank_row  [NUM_BANKS],
   output      logic [OCTET_W-1:0] bank_data [NUM_BANKS]
);

   // Consecutive addresses: each bank is claimed by at most one lane
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_we[b]   = 1'b0;
         bank_row[b]  = base_row;
         bank_data[b] = '0;
         for (int k = 0; k < LANES; k++) begin
            if (lane_wr[k].valid && (lane_wr[k].bank == BANK_W'(b))) begin
               bank_we[b]   = 1'b1;
               bank_row[b]  = base_row + ROW_W'(lane_wr[k].wrap);
               bank_data[b] = lane_wr[k].data;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/devicenet_fragment_reassembler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fragmented-message reassembler for DeviceNet-style frame bodies.
// req_chan (sink) carries one transaction per frame body or per read. A feed
// transaction (func 0) appends, restarts or replaces the stored message and
// reports ignored / started / progress / complete / error. A read transaction
// (func 1) returns one message octet, or zero at or past the current length.
// rsp_chan (source) returns exactly one transaction per request, in order,
// always carrying the message length and the assembling flag after the item.
// Sequence per item: accept, execute, load; rsp valid rises as the load step
// ends. A request is accepted only in the idle state, so a new item is taken
// only after the last one has been loaded.
// The message store is split into eight byte banks, with one lane per body
// octet past the header, so all data octets of a frame are written in the
// execute cycle; a read uses the registered bank output in the load cycle.
// A finished result sits in the rsp output register; the next request is
// accepted meanwhile, and only the load step waits while rsp is stalled.
// Reset (synchronous, active high) clears length, assembling flag, expected
// count and both handshakes. The store itself is not cleared: reads only reach
// octets below the length, which were all written. No clearing pass.
module devicenet_fragment_reassembler
   import dnfr_pkg::*;
#(
   parameter int MSG_MAX      = DEF_MSG_MAX,
   parameter int FRAME_OCTETS = DEF_FRAME_OCTETS
) (
   input wire logic  clock,
   input wire logic  reset,
   dnfr_chan_if.sink   req_chan,
   dnfr_chan_if.source rsp_chan
);

   localparam int LEN_W      = $clog2(MSG_MAX + 1);
   localparam int BANK_DEPTH = (MSG_MAX + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ROW_W      = $clog2(BANK_DEPTH);
   localparam int LANES      = FRAME_OCTETS - 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   // Control and message state
   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 asm_ff, asm_in;
   logic [COUNT_W-1:0]   exp_ff, exp_in;
   // Captured item and pending result
   req_type              item_ff, item_in;
   status_type           status_ff, status_in;
   logic                 rd_hit_ff, rd_hit_in;
   logic [BANK_W-1:0]    rd_bank_ff, rd_bank_in;
   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Decode of the captured item
   logic [OCTET_W-1:0]     body [FIELD_OCTETS];
   logic [FRAME_LEN_W-1:0] cnt;
   logic                   frag;
   frag_kind_type          fkind;
   logic [COUNT_W-1:0]     fcount;
   logic [1:0]             from;
   logic [FRAME_LEN_W-1:0] n_data;
   logic                   restart;
   logic [LEN_W-1:0]       base;
   logic [LEN_W-1:0]       base_sh;
   logic [LEN_W:0]         end_len;
   logic                   fit;
   logic                   do_write;
   status_type             feed_status;
   logic [LEN_W-1:0]       feed_len;
   logic                   feed_asm;
   logic [COUNT_W-1:0]     feed_exp;

   // Read path
   logic                       rd_start;
   logic                       idx_hit;
   logic [ROW_W+4:0]           idx_row_x;
   logic [ROW_W-1:0]           rd_row;
   logic [OCTET_W-1:0]         bank_rdata [NUM_BANKS];
   logic [OCTET_W-1:0]         read_byte;
   logic [LEN_W+MSG_LEN_W-1:0] len_x;
   logic                       load_go;

   // Lanes and bank writes
   lane_wr_type        lane_wr   [LANES];
   logic               bank_we   [NUM_BANKS];
   logic [ROW_W-1:0]   bank_row  [NUM_BANKS];
   logic [OCTET_W-1:0] bank_data [NUM_BANKS];
   logic               lane_en;

   assign body[0] = item_ff.hdr_octet;
   assign body[1] = item_ff.frag_octet;
   assign body[2] = item_ff.octet_2;
   assign body[3] = item_ff.octet_3;
   assign body[4] = item_ff.octet_4;
   assign body[5] = item_ff.octet_5;
   assign body[6] = item_ff.octet_6;
   assign body[7] = item_ff.octet_7;

   // Feed decision: clamp the body length, classify the frame, check fit
   always_comb begin
      cnt = (item_ff.frame_len > FRAME_LEN_W'(FRAME_OCTETS)) ?
            FRAME_LEN_W'(FRAME_OCTETS) : item_ff.frame_len;
      frag   = body[0][OCTET_W-1];
      fkind  = frag_kind_type'(body[1][OCTET_W-1 -: 2]);
      fcount = body[1][COUNT_W-1:0];
      from   = frag ? 2'd2 : 2'd1;
      n_data = (cnt > {2'b00, from}) ? (cnt - {2'b00, from}) : '0;

      // Unfragmented and first fragments start over at offset zero
      restart = !frag || (fkind == FT_FIRST);
      base    = restart ? '0 : len_ff;
      base_sh = base >> BANK_W;
      end_len = {1'b0, base} + (LEN_W+1)'(n_data);
      fit     = (end_len <= (LEN_W+1)'(MSG_MAX));

      feed_status = ST_IGNORED;
      feed_len    = len_ff;
      feed_asm    = asm_ff;
      feed_exp    = exp_ff;
      do_write    = 1'b0;

      if (cnt == '0) begin
         feed_status = ST_IGNORED;
      end else if (!frag) begin
         feed_asm = 1'b0;
         feed_exp = '0;
         if (fit) begin
            do_write    = 1'b1;
            feed_len    = end_len[LEN_W-1:0];
            feed_status = ST_COMPLETE;
         end else begin
            feed_len    = '0;
            feed_status = ST_ERROR;
         end
      end else if (cnt < FRAME_LEN_W'(2)) begin
         // Fragmented mark without a type octet: report, keep state
         feed_status = ST_ERROR;
      end else begin
         case (fkind)
            FT_FIRST: begin
               feed_asm = 1'b1;
               feed_exp = fcount + COUNT_W'(1);
               if (fit) begin
                  do_write    = 1'b1;
                  feed_len    = end_len[LEN_W-1:0];
                  feed_status = ST_STARTED;
               end else begin
                  feed_len    = '0;
                  feed_status = ST_ERROR;
               end
            end
            FT_ACK: begin
               feed_status = ST_IGNORED;
            end
            FT_MIDDLE, FT_LAST: begin
               if (!asm_ff || (fcount != exp_ff) || !fit) begin
                  // Out of sequence or overflow: drop the message
                  feed_len    = '0;
                  feed_asm    = 1'b0;
                  feed_exp    = '0;
                  feed_status = ST_ERROR;
               end else begin
                  do_write = 1'b1;
                  feed_len = end_len[LEN_W-1:0];
                  if (fkind == FT_MIDDLE) begin
                     feed_exp    = fcount + COUNT_W'(1);
                     feed_status = ST_PROGRESS;
                  end else begin
                     feed_asm    = 1'b0;
                     feed_status = ST_COMPLETE;
                  end
               end
            end
            default: begin
               feed_status = ST_IGNORED;
            end
         endcase
      end
   end

   // One lane per body octet position past the header
   assign lane_en = (state_ff == S_EXEC) && !item_ff.func && do_write;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      dnfr_lane #(
         .POS (k + 1)
      ) u_lane (
         .en      (lane_en),
         .cnt     (cnt),
         .from    (from),
         .base_lo (base[BANK_W-1:0]),
         .octet   (body[k + 1]),
         .wr      (lane_wr[k])
      );
   end

   dnfr_merge #(
      .LANES (LANES),
      .ROW_W (ROW_W)
   ) u_merge (
      .lane_wr   (lane_wr),
      .base_row  (base_sh[ROW_W-1:0]),
      .bank_we   (bank_we),
      .bank_row  (bank_row),
      .bank_data (bank_data)
   );

   // Read address: bank from the low bits, row from the rest
   always_comb begin
      idx_hit   = ({{LEN_W{1'b0}}, item_ff.read_index} <
                   {{READ_IDX_W{1'b0}}, len_ff});
      idx_row_x = {{ROW_W{1'b0}}, item_ff.read_index[READ_IDX_W-1:BANK_W]};
      rd_row    = idx_row_x[ROW_W-1:0];
      rd_start  = (state_ff == S_EXEC) && item_ff.func && idx_hit;
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      dnfr_ram #(
         .WIDTH (OCTET_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_row[b]),
         .wr_data (bank_data[b]),
         .rd_en   (rd_start),
         .rd_addr (rd_row),
         .rd_data (bank_rdata[b])
      );
   end

   always_comb begin
      read_byte = rd_hit_ff ? bank_rdata[rd_bank_ff] : '0;
      len_x     = {{MSG_LEN_W{1'b0}}, len_ff};
      load_go   = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_chan.ready);
   end

   // Sequencer: accept, execute (update state, write banks, start read), load
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      asm_in       = asm_ff;
      exp_in       = exp_ff;
      item_in      = item_ff;
      status_in    = status_ff;
      rd_hit_in    = rd_hit_ff;
      rd_bank_in   = rd_bank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Retire a taken result first; a load below may refill the register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               item_in  = req_chan.data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (item_ff.func) begin
               status_in  = ST_IGNORED;
               rd_hit_in  = idx_hit;
               rd_bank_in = item_ff.read_index[BANK_W-1:0];
            end else begin
               status_in  = feed_status;
               rd_hit_in  = 1'b0;
               rd_bank_in = '0;
               len_in     = feed_len;
               asm_in     = feed_asm;
               exp_in     = feed_exp;
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // Hold here while the output register is still occupied
            if (load_go) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.msg_len     = len_x[MSG_LEN_W-1:0];
               rsp_data_in.in_progress = asm_ff;
               rsp_data_in.read_byte   = read_byte;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         asm_ff       <= 1'b0;
         exp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         asm_ff       <= asm_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      status_ff   <= status_in;
      rd_hit_ff   <= rd_hit_in;
      rd_bank_ff  <= rd_bank_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Stored length never runs past the store
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MSG_MAX))
      else $error("message length beyond store size");

   // Message state moves only in the execute step
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> ($stable(len_ff) && $stable(asm_ff) && $stable(exp_ff)))
      else $error("message state changed outside execute");

   // A new result appears only out of the load step
   a_rsp_from_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOAD))
      else $error("result raised outside load");

   // Bank writes happen only while executing a feed
   a_write_exec : assert property (@(posedge clock) disable iff (reset)
      lane_en |-> (state_ff == S_EXEC) && !item_ff.func && !rd_start)
      else $error("bank write outside feed execute");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import dnfr_pkg::*;
();

   localparam int MSG_MAX      = DEF_MSG_MAX;
   localparam int FRAME_OCTETS = DEF_FRAME_OCTETS;
   localparam int ITEM_TARGET  = 450;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REQ_W        = $bits(req_type);

   bit   clock;
   logic reset = 1'b1;

   dnfr_chan_if #(.payload_type(req_type)) req_if ();
   dnfr_chan_if #(.payload_type(rsp_type)) rsp_if ();

   devicenet_fragment_reassembler #(
      .MSG_MAX      (MSG_MAX),
      .FRAME_OCTETS (FRAME_OCTETS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // 10 ns period; the first rising edge falls at 5 ns
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Replies still owed by the block, oldest first
   rsp_type pending_replies[$];
   int unsigned mismatch_count;
   int unsigned item_count;
   int unsigned cycle_count;

   // Idle controls shared by the two sides
   bit req_quiet;
   bit rsp_quiet;
   bit hold_rsp;

   // ------------------------------------------------------------------------
   // Reassembly predictor: own copy of the message, its length, the assembling
   // flag and the fragment count that the next middle or last must carry.
   // ------------------------------------------------------------------------
   logic [OCTET_W-1:0] msg_octets [MSG_MAX];
   int unsigned        msg_length;
   bit                 assembling_q;
   logic [COUNT_W-1:0] count_due;

   // The store itself is left alone: reads only reach octets below the length
   function automatic void clear_message();
      msg_length   = 0;
      assembling_q = 1'b0;
      count_due    = '0;
   endfunction

   // Append body octets [from, upto); refuse the whole append on overflow
   function automatic bit append_to_message(
      logic [FIELD_OCTETS-1:0][OCTET_W-1:0] body,
      int unsigned from,
      int unsigned upto
   );
      int unsigned n;
      n = (upto > from) ? upto - from : 0;
      if (msg_length + n > MSG_MAX) return 1'b0;
      for (int unsigned i = 0; i < n; i++) msg_octets[msg_length + i] = body[from + i];
      msg_length += n;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_reassembly(req_type r);
      rsp_type                              res;
      logic [FIELD_OCTETS-1:0][OCTET_W-1:0] body;
      int unsigned                          n_octets;
      frag_kind_type                        kind;
      logic [COUNT_W-1:0]                   count;
      status_type                           st;
      res      = '0;
      st       = ST_IGNORED;
      body     = {r.octet_7, r.octet_6, r.octet_5, r.octet_4,
                  r.octet_3, r.octet_2, r.frag_octet, r.hdr_octet};
      n_octets = (r.frame_len > FRAME_OCTETS) ? FRAME_OCTETS : r.frame_len;
      kind     = frag_kind_type'(r.frag_octet[7:6]);
      count    = r.frag_octet[COUNT_W-1:0];
      if (r.func) begin
         if (r.read_index < msg_length) res.read_byte = msg_octets[r.read_index];
      end else if (n_octets == 0) begin
         st = ST_IGNORED;
      end else if (!r.hdr_octet[7]) begin
         // unfragmented body replaces the whole message
         clear_message();
         st = append_to_message(body, 1, n_octets) ? ST_COMPLETE : ST_ERROR;
      end else if (n_octets < 2) begin
         // fragmented mark but no type octet: state untouched
         st = ST_ERROR;
      end else if (kind == FT_FIRST) begin
         clear_message();
         assembling_q = 1'b1;
         count_due    = count + 1'b1;
         st = append_to_message(body, 2, n_octets) ? ST_STARTED : ST_ERROR;
      end else if (kind == FT_ACK) begin
         st = ST_IGNORED;
      end else if (!assembling_q || count != count_due ||
                   !append_to_message(body, 2, n_octets)) begin
         // out of sequence or overflow: drop the message
         clear_message();
         st = ST_ERROR;
      end else if (kind == FT_MIDDLE) begin
         count_due = count + 1'b1;
         st = ST_PROGRESS;
      end else begin
         assembling_q = 1'b0;
         st = ST_COMPLETE;
      end
      res.status      = st;
      res.msg_len     = msg_length[MSG_LEN_W-1:0];
      res.in_progress = assembling_q;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------------
   function automatic req_type feed_item(logic [FRAME_LEN_W-1:0] len, logic [7:0] hdr,
                                         logic [7:0] frag, logic [47:0] data);
      req_type r;
      r            = '0;
      r.frame_len  = len;
      r.hdr_octet  = hdr;
      r.frag_octet = frag;
      {r.octet_2, r.octet_3, r.octet_4, r.octet_5, r.octet_6, r.octet_7} = data;
      r.read_index = READ_IDX_W'($urandom);
      return r;
   endfunction

   function automatic req_type read_item(logic [READ_IDX_W-1:0] idx);
      req_type r;
      r            = '0;
      r.func       = 1'b1;
      r.frame_len  = FRAME_LEN_W'($urandom);
      r.read_index = idx;
      return r;
   endfunction

   function automatic logic [7:0] frag_code(frag_kind_type k, logic [COUNT_W-1:0] c);
      return {k, c};
   endfunction

   function automatic logic [47:0] random_data();
      return {16'($urandom), $urandom};
   endfunction

   function automatic rsp_type outcome(status_type st, int unsigned len, bit prog);
      rsp_type res;
      res             = '0;
      res.status      = st;
      res.msg_len     = MSG_LEN_W'(len);
      res.in_progress = prog;
      return res;
   endfunction

   // Mostly full frames, some short ones, a few with an overlong length code
   function automatic logic [FRAME_LEN_W-1:0] frag_frame_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return FRAME_LEN_W'($urandom_range(FRAME_OCTETS + 1, 15));
      if (r < 6) return FRAME_LEN_W'($urandom_range(2, FRAME_OCTETS - 1));
      return FRAME_LEN_W'(FRAME_OCTETS);
   endfunction

   // ------------------------------------------------------------------------
   // Request side: draw a gap, offer the transaction, hold it until accepted,
   // then record what the block owes for it.
   // ------------------------------------------------------------------------
   task automatic send_item(req_type item, bit typed, rsp_type want);
      int unsigned gap;
      rsp_type     predicted;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge: advance the predictor
      predicted = predict_reassembly(item);
      pending_replies.push_back(typed ? want : predicted);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_frame(frag_kind_type k, logic [COUNT_W-1:0] c,
                             logic [FRAME_LEN_W-1:0] len);
      send_item(feed_item(len, {1'b1, 7'($urandom)}, frag_code(k, c), random_data()),
                1'b0, '0);
   endtask

   // Reads mostly land inside the current message, some anywhere
   task automatic read_some(int unsigned n);
      logic [READ_IDX_W-1:0] idx;
      repeat (n) begin
         if (msg_length > 0 && $urandom_range(0, 3) != 0)
            idx = READ_IDX_W'($urandom_range(0, msg_length - 1));
         else
            idx = READ_IDX_W'($urandom);
         send_item(read_item(idx), 1'b0, '0);
      end
   endtask

   // First, n_mid middles, last; now and then slip a count, restart,
   // or wedge in an acknowledge or a read
   task automatic send_fragments(int unsigned n_mid);
      logic [COUNT_W-1:0] c;
      int unsigned        slip;
      c = COUNT_W'($urandom);
      send_frame(FT_FIRST, c, frag_frame_len());
      for (int unsigned i = 0; i <= n_mid; i++) begin
         c    = c + 1'b1;
         slip = $urandom_range(0, 39);
         if (slip == 0) c = c + COUNT_W'($urandom_range(1, 63));
         else if (slip == 1) send_frame(FT_ACK, COUNT_W'($urandom), frag_frame_len());
         else if (slip == 2) read_some(1);
         else if (slip == 3) send_frame(FT_FIRST, c - 1'b1, frag_frame_len());
         send_frame((i == n_mid) ? FT_LAST : FT_MIDDLE, c, frag_frame_len());
      end
   endtask

   // Lower valid and hold until every owed reply has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Directed table: extremes, every fragment type and each corner. Rows with
   // typed = 1 carry a reply that can be read off directly; the rest go
   // through the predictor.
   // ------------------------------------------------------------------------
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic dir_row_type dir_row(req_type item, bit typed, rsp_type want);
      dir_row_type d;
      d.item  = item;
      d.typed = typed;
      d.want  = want;
      return d;
   endfunction

   function automatic void build_directed();
      // reads right after reset, both ends of the index
      dir_rows.push_back(dir_row(read_item(8'd0), 1'b1, outcome(ST_IGNORED, 0, 1'b0)));
      dir_rows.push_back(dir_row(read_item(8'd255), 1'b1, outcome(ST_IGNORED, 0, 1'b0)));
      // empty body
      dir_rows.push_back(dir_row(feed_item(4'd0, 8'hFF, 8'h00, '1), 1'b1,
                                 outcome(ST_IGNORED, 0, 1'b0)));
      // fragmented mark without a type octet
      dir_rows.push_back(dir_row(feed_item(4'd1, 8'h80, 8'hFF, '1), 1'b1,
                                 outcome(ST_ERROR, 0, 1'b0)));
      // full unfragmented body, all ones
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h00, 8'hFF, '1), 1'b1,
                                 outcome(ST_COMPLETE, 7, 1'b0)));
      dir_rows.push_back(dir_row(read_item(8'd6), 1'b0, '0));
      dir_rows.push_back(dir_row(read_item(8'd7), 1'b1, outcome(ST_IGNORED, 7, 1'b0)));
      // overlong length code is clipped to a full frame
      dir_rows.push_back(dir_row(feed_item(4'd15, 8'h7F, 8'h12, 48'h3456789ABCDE), 1'b1,
                                 outcome(ST_COMPLETE, 7, 1'b0)));
      // header alone: empty message
      dir_rows.push_back(dir_row(feed_item(4'd1, 8'h00, 8'h00, '0), 1'b1,
                                 outcome(ST_COMPLETE, 0, 1'b0)));
      // middle and last with nothing being assembled
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_MIDDLE, 6'd0),
                                           random_data()), 1'b1,
                                 outcome(ST_ERROR, 0, 1'b0)));
      dir_rows.push_back(dir_row(feed_item(4'd3, 8'h80, frag_code(FT_LAST, 6'd0),
                                           random_data()), 1'b1,
                                 outcome(ST_ERROR, 0, 1'b0)));
      // first with the top count, so the next count wraps to zero
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'hFF, frag_code(FT_FIRST, 6'd63),
                                           48'hA55A00FF0180), 1'b1,
                                 outcome(ST_STARTED, 6, 1'b1)));
      // acknowledge and a typeless fragment leave the message alone
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_ACK, 6'd63),
                                           random_data()), 1'b1,
                                 outcome(ST_IGNORED, 6, 1'b1)));
      dir_rows.push_back(dir_row(feed_item(4'd1, 8'hC3, 8'h00, random_data()), 1'b1,
                                 outcome(ST_ERROR, 6, 1'b1)));
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_MIDDLE, 6'd0),
                                           random_data()), 1'b0, '0));
      // count out of sequence drops the message
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_LAST, 6'd5),
                                           random_data()), 1'b1,
                                 outcome(ST_ERROR, 0, 1'b0)));
      // first with no data octets, then middle with an overlong code, then last
      dir_rows.push_back(dir_row(feed_item(4'd2, 8'h80, frag_code(FT_FIRST, 6'd10),
                                           random_data()), 1'b1,
                                 outcome(ST_STARTED, 0, 1'b1)));
      dir_rows.push_back(dir_row(feed_item(4'd12, 8'h80, frag_code(FT_MIDDLE, 6'd11),
                                           random_data()), 1'b0, '0));
      dir_rows.push_back(dir_row(feed_item(4'd5, 8'h80, frag_code(FT_LAST, 6'd12),
                                           random_data()), 1'b0, '0));
      dir_rows.push_back(dir_row(read_item(8'd0), 1'b0, '0));
      dir_rows.push_back(dir_row(read_item(8'd8), 1'b0, '0));
      dir_rows.push_back(dir_row(read_item(8'd9), 1'b1, outcome(ST_IGNORED, 9, 1'b0)));
      // last once the message is complete
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_LAST, 6'd13),
                                           random_data()), 1'b1,
                                 outcome(ST_ERROR, 0, 1'b0)));
      dir_rows.push_back(dir_row(feed_item(4'd8, 8'h80, frag_code(FT_FIRST, 6'd0),
                                           random_data()), 1'b1,
                                 outcome(ST_STARTED, 6, 1'b1)));
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned pick;
      bit          hold_done;
      bit          pause_done;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      clear_message();
      build_directed();
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      // let the block catch up before the random part
      wait_drained();

      while (item_count < ITEM_TARGET) begin
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         if (!hold_done && item_count >= 150) begin
            // stall the reply side for a long stretch while requests keep coming
            hold_done = 1'b1;
            hold_rsp  = 1'b1;
            req_quiet = 1'b1;
         end
         if (!pause_done && item_count >= 320) begin
            pause_done = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4, 5: begin
               if ($urandom_range(0, 6) == 0) send_fragments($urandom_range(36, 52));
               else send_fragments($urandom_range(0, 6));
               read_some($urandom_range(1, 4));
            end
            6: begin
               send_item(feed_item(FRAME_LEN_W'($urandom_range(1, 15)), {1'b0, 7'($urandom)},
                                   8'($urandom), random_data()), 1'b0, '0);
               read_some($urandom_range(1, 3));
            end
            7: begin
               // raw noise: any field, any value
               send_item(req_type'(REQ_W'({$urandom, $urandom, $urandom})), 1'b0, '0);
            end
            8: begin
               read_some($urandom_range(1, 4));
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: send_item(feed_item(4'd0, 8'($urandom), 8'($urandom), random_data()),
                               1'b0, '0);
                  1: send_frame(FT_ACK, COUNT_W'($urandom), frag_frame_len());
                  default: send_item(feed_item(4'd1, {1'b1, 7'($urandom)}, 8'($urandom),
                                               random_data()), 1'b0, '0);
               endcase
            end
         endcase
      end

      // all stimulus accepted: drain, then wait for stragglers to show up
      req_if.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("[devicenet_fragment_reassembler] OK");
      else
         $display("[devicenet_fragment_reassembler] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Reply side: draw a stall per transaction (or take the long hold when
   // asked), then accept and compare against the oldest owed reply.
   // ------------------------------------------------------------------------
   initial begin : reply_check
      int unsigned stall;
      rsp_type     got;
      rsp_type     want;
      rsp_if.ready <= 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            stall    = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            for (int unsigned k = 0; k < stall; k++) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got = rsp_if.data;
         if (pending_replies.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected reply: status %0d len %0d prog %0d byte %02h",
                        got.status, got.msg_len, got.in_progress, got.read_byte);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.msg_len !== want.msg_len ||
                got.in_progress !== want.in_progress || got.read_byte !== want.read_byte)
            begin
               if (mismatch_count < 10)
                  $display({"reply mismatch (exp/got): status %0d/%0d len %0d/%0d",
                            " prog %0d/%0d byte %02h/%02h"},
                           want.status, got.status, want.msg_len, got.msg_len,
                           want.in_progress, got.in_progress, want.read_byte, got.read_byte);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   // Watchdog: a hang or a lost reply ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[devicenet_fragment_reassembler] ERROR");
         $finish;
      end
   end

endmodule
